FILE: design/kce_pkg.sv
// Shared codes and handshake structs for the keypad calculator engine.
// Used by keypad_calculator_engine, kce_muldiv and the testbench. No dependencies.
package kce_pkg;

    // Key codes, also used as operator codes in the pending/previous registers
    localparam logic [2:0] OP_DIGIT  = 3'd0;
    localparam logic [2:0] OP_PLUS   = 3'd1;
    localparam logic [2:0] OP_MINUS  = 3'd2;
    localparam logic [2:0] OP_TIMES  = 3'd3;
    localparam logic [2:0] OP_DIVIDE = 3'd4;
    localparam logic [2:0] OP_POWER  = 3'd5;
    localparam logic [2:0] OP_EQUALS = 3'd6;
    localparam logic [2:0] OP_CLEAR  = 3'd7;

    // Pending operator with nothing pending
    localparam logic [2:0] PEND_NONE = 3'd0;

    // Status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    // Command to the serial multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
        logic neg;
    } t_md_cmd;

    // Status back from the serial multiply/divide unit
    typedef struct packed {
        logic done;
        logic ovf;
    } t_md_sts;

endpackage

FILE: design/kce_muldiv.sv
// Bit-serial fixed point multiply and restoring divide on magnitudes, with
// saturation to the signed range. Depends on kce_pkg.
module kce_muldiv import kce_pkg::*; #(
    parameter int W    = 64,
    parameter int FRAC = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_md_cmd      i_cmd,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output t_md_sts      o_sts,
    output logic [W-1:0] o_res
);

    localparam int NW = W + FRAC;
    localparam int CNW = $clog2(NW + 1);

    typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_FIN} t_ustate;

    t_ustate            r_state;
    logic [CNW-1:0]     r_cnt;
    logic               r_is_div;
    logic               r_neg;
    logic [W-1:0]       r_a;
    logic [W-1:0]       r_b;
    logic [2*W-1:0]     r_acc;
    logic [NW-1:0]      r_num;
    logic [W-1:0]       r_rem;
    logic [W-1:0]       r_res;
    logic               r_done;
    logic               r_ovf;

    logic [W:0]         n_sum;
    logic [W:0]         n_rr;
    logic               n_ge;
    logic [W:0]         n_diff;
    logic [2*W-1:0]     n_q;
    logic [2*W-1:0]     n_lim;
    logic               n_ovf;

    // One add per step for multiply, one compare/subtract per step for divide
    always_comb begin
        n_sum  = {1'b0, r_acc[2*W-1:W]} + (r_b[0] ? {1'b0, r_a} : {(W+1){1'b0}});
        n_rr   = {r_rem, r_num[NW-1]};
        n_ge   = n_rr >= {1'b0, r_b};
        n_diff = n_rr - {1'b0, r_b};
        n_q    = r_is_div ? r_acc : (r_acc >> FRAC);
        n_lim  = {{(2*W-1){1'b0}}, 1'b1} << (W-1);
        if (!r_neg) begin
            n_lim = n_lim - 1'b1;
        end
        n_ovf  = n_q > n_lim;
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                U_IDLE: begin
                    if (i_cmd.start) begin
                        r_is_div <= i_cmd.is_div;
                        r_neg    <= i_cmd.neg;
                        r_a      <= i_a;
                        r_b      <= i_b;
                        r_acc    <= '0;
                        r_rem    <= '0;
                        r_num    <= NW'(i_a) << FRAC;
                        r_cnt    <= i_cmd.is_div ? CNW'(NW) : CNW'(W);
                        r_state  <= i_cmd.is_div ? U_DIV : U_MUL;
                    end
                end
                U_MUL: begin
                    // Shift-add, multiplier bits from the low end
                    r_acc   <= {n_sum, r_acc[W-1:1]};
                    r_b     <= r_b >> 1;
                    r_cnt   <= r_cnt - 1'b1;
                    if (r_cnt == CNW'(1)) begin
                        r_state <= U_FIN;
                    end
                end
                U_DIV: begin
                    // Restoring divide, one quotient bit per cycle
                    r_rem   <= n_ge ? n_diff[W-1:0] : n_rr[W-1:0];
                    r_num   <= r_num << 1;
                    r_acc   <= {r_acc[2*W-2:0], n_ge};
                    r_cnt   <= r_cnt - 1'b1;
                    if (r_cnt == CNW'(1)) begin
                        r_state <= U_FIN;
                    end
                end
                U_FIN: begin
                    // Saturate or apply sign
                    r_ovf  <= n_ovf;
                    if (n_ovf) begin
                        r_res <= r_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                    end else begin
                        r_res <= r_neg ? (~n_q[W-1:0] + 1'b1) : n_q[W-1:0];
                    end
                    r_done  <= 1'b1;
                    r_state <= U_IDLE;
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.ovf  = r_ovf;
    assign o_res      = r_res;

endmodule

FILE: design/keypad_calculator_engine.sv
// Keypad calculator engine: one key press in, one display result out.
// Times and divide use the serial kce_muldiv unit; power repeats serial multiplies,
// up to MAX_POWER_STEPS. One key in flight at a time; a stalled result holds the
// engine until the output register is free.
// Synchronous active-low reset clears entry, running result, operators, shown value
// and output valid.
module keypad_calculator_engine import kce_pkg::*; #(
    parameter int VALUE_BITS      = 64,
    parameter int FRAC_BITS       = 16,
    parameter int MAX_POWER_STEPS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [2:0]            i_op,
    input  logic [3:0]            i_digit,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [VALUE_BITS-1:0] o_display_value,
    output logic                  o_display_changed,
    output logic [1:0]            o_status
);

    localparam int W  = VALUE_BITS;
    localparam int XW = W + 5;
    localparam int CW = $clog2(MAX_POWER_STEPS + 1);
    localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_DIG1, S_DIG2, S_APPLY, S_ADD, S_MD,
        S_PINIT, S_PLOOP, S_PWAIT, S_FIN, S_OUT
    } t_state;

    function automatic logic [W-1:0] f_mag(input logic [W-1:0] x);
        f_mag = x[W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic f_ovf(input logic neg, input logic [XW-1:0] m);
        logic [XW-1:0] lim;
        lim = {{(XW-1){1'b0}}, 1'b1} << (W-1);
        if (!neg) begin
            lim = lim - 1'b1;
        end
        f_ovf = m > lim;
    endfunction

    function automatic logic [W-1:0] f_val(input logic neg, input logic [XW-1:0] m);
        if (f_ovf(neg, m)) begin
            f_val = neg ? VMIN : VMAX;
        end else begin
            f_val = neg ? (~m[W-1:0] + 1'b1) : m[W-1:0];
        end
    endfunction

    // Sign-magnitude add; returns {overflow, value}
    function automatic logic [W:0] f_addsm(input logic na, input logic [XW-1:0] ma,
                                           input logic nb, input logic [XW-1:0] mb);
        logic          neg;
        logic [XW-1:0] m;
        if (na == nb) begin
            m   = ma + mb;
            neg = na;
        end else if (ma >= mb) begin
            m   = ma - mb;
            neg = na;
        end else begin
            m   = mb - ma;
            neg = nb;
        end
        f_addsm = {f_ovf(neg, m), f_val(neg, m)};
    endfunction

    t_state          r_state;
    logic [W-1:0]    r_entry;
    logic [W-1:0]    r_run;
    logic [W-1:0]    r_shown;
    logic [2:0]      r_pend;
    logic [2:0]      r_prev;
    logic [2:0]      r_key;
    logic [3:0]      r_digit;
    logic [2:0]      r_kind;
    logic [W-1:0]    r_opa;
    logic [W-1:0]    r_opb;
    logic [W-1:0]    r_res;
    logic [1:0]      r_st;
    logic            r_chg;
    logic [CW-1:0]   r_cnt;
    logic            r_sat;
    logic            r_go;
    logic            r_is_div;
    logic [W-1:0]    r_ua;
    logic [W-1:0]    r_ub;
    logic            r_uneg;
    logic            r_out_valid;
    logic [W-1:0]    r_disp;
    logic            r_ochg;
    logic [1:0]      r_ost;

    t_md_cmd         s_cmd;
    t_md_sts         s_sts;
    logic [W-1:0]    s_md_res;

    logic [3:0]      n_dsat;
    logic [XW-1:0]   n_m10;
    logic [W:0]      n_dig;
    logic [W:0]      n_add;
    logic [W-1:0]    n_pn;
    logic [CW-1:0]   n_pcnt;
    logic [XW-1:0]   n_one;

    assign s_cmd.start  = r_go;
    assign s_cmd.is_div = r_is_div;
    assign s_cmd.neg    = r_uneg;

    kce_muldiv #(.W(W), .FRAC(FRAC_BITS)) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (s_cmd),
        .i_a     (r_ua),
        .i_b     (r_ub),
        .o_sts   (s_sts),
        .o_res   (s_md_res)
    );

    // Narrow arithmetic for digit entry, add/subtract and power setup
    always_comb begin
        n_dsat = (r_digit > 4'd9) ? 4'd9 : r_digit;
        n_m10  = (XW'(f_mag(r_entry)) << 3) + (XW'(f_mag(r_entry)) << 1);
        n_dig  = f_addsm(r_res[W-1], XW'(f_mag(r_res)), 1'b0, XW'(n_dsat) << FRAC_BITS);
        n_add  = f_addsm(r_opa[W-1], XW'(f_mag(r_opa)),
                         r_opb[W-1] ^ (r_kind == OP_MINUS), XW'(f_mag(r_opb)));
        n_pn   = r_opb[W-1] ? '0 : (r_opb >> FRAC_BITS);
        if (n_pn > W'(MAX_POWER_STEPS)) begin
            n_pcnt = (n_pn[0] ^ MAX_POWER_STEPS[0]) ? CW'(MAX_POWER_STEPS - 1)
                                                     : CW'(MAX_POWER_STEPS);
        end else begin
            n_pcnt = n_pn[CW-1:0];
        end
        n_one  = {{(XW-1){1'b0}}, 1'b1} << FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        r_go <= 1'b0;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_entry     <= '0;
            r_run       <= '0;
            r_shown     <= '0;
            r_pend      <= PEND_NONE;
            r_prev      <= PEND_NONE;
            r_out_valid <= 1'b0;
            r_sat       <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_key   <= i_op;
                        r_digit <= i_digit;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_st  <= ST_OK;
                    r_chg <= 1'b1;
                    r_opa <= r_run;
                    r_opb <= r_entry;
                    unique case (r_key)
                        OP_DIGIT: begin
                            // A digit after equals starts a new calculation
                            if (r_pend == OP_EQUALS) begin
                                r_entry <= '0;
                                r_run   <= '0;
                                r_pend  <= PEND_NONE;
                            end
                            r_state <= S_DIG1;
                        end
                        OP_EQUALS: begin
                            r_pend <= OP_EQUALS;
                            if (r_pend == OP_EQUALS) begin
                                r_kind <= r_prev;
                                if (r_prev == PEND_NONE) begin
                                    r_res   <= '0;
                                    r_state <= S_FIN;
                                end else begin
                                    r_state <= S_APPLY;
                                end
                            end else if (r_pend != PEND_NONE) begin
                                r_kind  <= r_pend;
                                r_state <= S_APPLY;
                            end else begin
                                r_res   <= r_run;
                                r_state <= S_FIN;
                            end
                        end
                        OP_CLEAR: begin
                            r_entry <= '0;
                            r_run   <= '0;
                            r_shown <= '0;
                            r_pend  <= PEND_NONE;
                            r_prev  <= PEND_NONE;
                            r_state <= S_OUT;
                        end
                        default: begin
                            // Operator key: fold what is pending
                            r_chg   <= 1'b0;
                            r_entry <= '0;
                            r_pend  <= r_key;
                            r_prev  <= r_key;
                            r_kind  <= r_pend;
                            if (r_pend == PEND_NONE) begin
                                r_res   <= r_entry;
                                r_state <= S_FIN;
                            end else if (r_pend == OP_EQUALS) begin
                                r_res   <= r_run;
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_APPLY;
                            end
                        end
                    endcase
                end
                S_DIG1: begin
                    // entry * 10, saturated
                    r_res <= f_val(r_entry[W-1], n_m10);
                    if (f_ovf(r_entry[W-1], n_m10)) begin
                        r_st <= ST_OVF;
                    end
                    r_state <= S_DIG2;
                end
                S_DIG2: begin
                    r_entry <= n_dig[W-1:0];
                    r_shown <= n_dig[W-1:0];
                    if (n_dig[W]) begin
                        r_st <= ST_OVF;
                    end
                    r_state <= S_OUT;
                end
                S_APPLY: begin
                    r_uneg   <= r_opa[W-1] ^ r_opb[W-1];
                    r_ua     <= f_mag(r_opa);
                    r_ub     <= f_mag(r_opb);
                    r_is_div <= (r_kind == OP_DIVIDE);
                    unique case (r_kind) inside
                        OP_PLUS, OP_MINUS: r_state <= S_ADD;
                        OP_TIMES: begin
                            r_go    <= 1'b1;
                            r_state <= S_MD;
                        end
                        OP_DIVIDE: begin
                            if (r_opb == '0) begin
                                r_st    <= ST_DZ;
                                r_res   <= r_opa[W-1] ? VMIN : ((r_opa == '0) ? '0 : VMAX);
                                r_state <= S_FIN;
                            end else begin
                                r_go    <= 1'b1;
                                r_state <= S_MD;
                            end
                        end
                        OP_POWER: r_state <= S_PINIT;
                        default: begin
                            r_res   <= '0;
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_ADD: begin
                    r_res <= n_add[W-1:0];
                    if (n_add[W]) begin
                        r_st <= ST_OVF;
                    end
                    r_state <= S_FIN;
                end
                S_MD: begin
                    if (s_sts.done) begin
                        r_res <= s_md_res;
                        if (s_sts.ovf) begin
                            r_st <= ST_OVF;
                        end
                        r_state <= S_FIN;
                    end
                end
                S_PINIT: begin
                    // Start from 1.0 and a capped, parity-kept count
                    r_res <= f_val(1'b0, n_one);
                    if (f_ovf(1'b0, n_one)) begin
                        r_st <= ST_OVF;
                    end
                    r_cnt   <= n_pcnt;
                    r_sat   <= 1'b0;
                    r_state <= S_PLOOP;
                end
                S_PLOOP: begin
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end else if (r_sat) begin
                        // Saturated: flip sign per negative factor
                        if (r_opa[W-1]) begin
                            r_res <= (r_res == VMAX) ? VMIN : VMAX;
                        end
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_ua     <= f_mag(r_res);
                        r_uneg   <= r_res[W-1] ^ r_opa[W-1];
                        r_ub     <= f_mag(r_opa);
                        r_is_div <= 1'b0;
                        r_go     <= 1'b1;
                        r_state  <= S_PWAIT;
                    end
                end
                S_PWAIT: begin
                    if (s_sts.done) begin
                        r_res <= s_md_res;
                        if (s_sts.ovf) begin
                            r_sat <= 1'b1;
                            r_st  <= ST_OVF;
                        end
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= S_PLOOP;
                    end
                end
                S_FIN: begin
                    r_run <= r_res;
                    if (r_key == OP_EQUALS) begin
                        r_shown <= r_res;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Hold until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_disp      <= r_shown;
                        r_ochg      <= r_chg;
                        r_ost       <= r_st;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_display_value   = r_disp;
    assign o_display_changed = r_ochg;
    assign o_status          = r_ost;

`ifndef ASSERT_OFF
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transaction accepted while one is in flight");
    a_pend_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != OP_CLEAR)
        else $error("clear key stored as pending operator");
    a_unit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_sts.done |-> (r_state == S_MD || r_state == S_PWAIT))
        else $error("serial unit finished with no operation waiting");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_OVF || o_status == ST_DZ))
        else $error("undefined status code");
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_display_value)
            && $stable(o_display_changed) && $stable(o_status)))
        else $error("result transaction changed while stalled");
`endif

endmodule

FILE: tb/sv/keypad_calculator_engine_tb.sv
// Self-checking testbench for keypad_calculator_engine: drives key presses
// through valid/ready and checks each display transaction with a built-in model or a typed-in expected result.
// Depends on kce_pkg and the keypad_calculator_engine RTL.
module keypad_calculator_engine_tb;
    import kce_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_KEYS = 115;
    localparam int          TAIL_KEYS   = 20;
    localparam int          CYCLE_LIMIT = 3000000;
    localparam logic [63:0] VMAX        = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VMIN        = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONE_FX      = 64'd1 << 16;

    typedef struct {
        logic [2:0]         op;
        logic [3:0]         digit;
        bit                 fixed;   // expected result typed in the table
        logic signed [63:0] value;
        logic               changed;
        logic [1:0]         status;
    } t_key;

    typedef struct {
        logic signed [63:0] value;
        logic               changed;
        logic [1:0]         status;
    } t_display;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [2:0]         i_op = OP_CLEAR;
    logic [3:0]         i_digit = 4'd0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [63:0]        o_display_value;
    logic               o_display_changed;
    logic [1:0]         o_status;

    t_key               keys[$];
    t_key               cur_key;
    t_display           pending_displays[$];
    bit                 tail_phase = 1'b0;
    bit                 keys_done = 1'b0;
    int                 errors = 0;
    int                 cycles = 0;
    int                 checked = 0;

    // Calculator state kept by the checker
    logic signed [63:0] calc_entry, calc_running, calc_shown;
    logic [2:0]         calc_pending, calc_previous;

    keypad_calculator_engine DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_op(i_op), .i_digit(i_digit),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_display_value(o_display_value), .o_display_changed(o_display_changed),
        .o_status(o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] magnitude(logic signed [63:0] a);
        return a[63] ? -a : a;
    endfunction

    // Clamp a sign/magnitude value to the signed range
    function automatic logic [63:0] clamp(bit neg, logic [127:0] m, inout bit ovf);
        logic [127:0] lim;
        lim = neg ? {64'd0, VMIN} : {64'd0, VMAX};
        if (m > lim) begin
            ovf = 1'b1;
            return neg ? VMIN : VMAX;
        end
        return neg ? -m[63:0] : m[63:0];
    endfunction

    function automatic logic [63:0] add_sm(bit na, logic [63:0] ma, bit nb,
                                           logic [63:0] mb, inout bit ovf);
        if (na == nb)
            return clamp(na, {64'd0, ma} + {64'd0, mb}, ovf);
        if (ma >= mb)
            return clamp(na, {64'd0, ma - mb}, ovf);
        return clamp(nb, {64'd0, mb - ma}, ovf);
    endfunction

    function automatic logic [63:0] fx_mul(logic signed [63:0] a, logic signed [63:0] b,
                                           inout bit ovf);
        logic [127:0] p;
        p = ({64'd0, magnitude(a)} * {64'd0, magnitude(b)}) >> 16;
        return clamp(a[63] != b[63], p, ovf);
    endfunction

    function automatic logic [63:0] fx_pow(logic signed [63:0] base, logic signed [63:0] ex,
                                           inout bit ovf);
        logic signed [63:0] r;
        logic [63:0]        n;
        bit                 sat, o;
        r = ONE_FX;
        sat = 1'b0;
        n = ex[63] ? 64'd0 : (ex >> 16);
        // Cap the count but keep its parity
        if (n > 64)
            n = ((n - 64) & 1) ? 64'd63 : 64'd64;
        for (int k = 0; k < n; k++) begin
            if (sat) begin
                if (base[63])
                    r = (r == VMAX) ? VMIN : VMAX;
            end else begin
                o = 1'b0;
                r = fx_mul(r, base, o);
                if (o) begin
                    sat = 1'b1;
                    ovf = 1'b1;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] fold(logic [2:0] k, logic signed [63:0] a,
                                         logic signed [63:0] b, inout logic [1:0] st);
        bit           ovf;
        logic [63:0]  r;
        logic [127:0] q;
        ovf = 1'b0;
        case (k)
            OP_PLUS:  r = add_sm(a[63], magnitude(a), b[63], magnitude(b), ovf);
            OP_MINUS: r = add_sm(a[63], magnitude(a), !b[63], magnitude(b), ovf);
            OP_TIMES: r = fx_mul(a, b, ovf);
            OP_DIVIDE: begin
                if (b == 0) begin
                    st = ST_DZ;
                    return (a > 0) ? VMAX : ((a < 0) ? VMIN : 64'd0);
                end
                q = ({64'd0, magnitude(a)} << 16) / {64'd0, magnitude(b)};
                r = clamp(a[63] != b[63], q, ovf);
            end
            OP_POWER: r = fx_pow(a, b, ovf);
            default:  return 64'd0;
        endcase
        if (ovf)
            st = ST_OVF;
        return r;
    endfunction

    function automatic void calc_clear();
        calc_entry = 0;
        calc_running = 0;
        calc_pending = PEND_NONE;
        calc_previous = PEND_NONE;
        calc_shown = 0;
    endfunction

    // Advance the checker state by one key and return the expected display
    function automatic t_display calc_press(logic [2:0] op, logic [3:0] digit);
        t_display     d;
        logic [1:0]   st;
        logic [63:0]  t, dv;
        bit           ovf;
        st = ST_OK;
        ovf = 1'b0;
        d.changed = 1'b1;
        if (op == OP_DIGIT) begin
            dv = (digit > 9) ? 64'd9 : {60'd0, digit};
            if (calc_pending == OP_EQUALS) begin
                calc_entry = 0;
                calc_running = 0;
                calc_pending = PEND_NONE;
            end
            t = clamp(calc_entry[63], {64'd0, magnitude(calc_entry)} * 128'd10, ovf);
            calc_entry = add_sm(t[63], magnitude(t), 1'b0, dv << 16, ovf);
            if (ovf)
                st = ST_OVF;
            calc_shown = calc_entry;
        end else if (op <= OP_POWER) begin
            if (calc_pending == PEND_NONE)
                calc_running = calc_entry;
            else if (calc_pending != OP_EQUALS)
                calc_running = fold(calc_pending, calc_running, calc_entry, st);
            calc_entry = 0;
            calc_pending = op;
            calc_previous = op;
            d.changed = 1'b0;
        end else if (op == OP_EQUALS) begin
            if (calc_pending == OP_EQUALS)
                calc_running = fold(calc_previous, calc_running, calc_entry, st);
            else if (calc_pending != PEND_NONE)
                calc_running = fold(calc_pending, calc_running, calc_entry, st);
            calc_shown = calc_running;
            calc_pending = OP_EQUALS;
        end else begin
            calc_clear();
        end
        d.value = calc_shown;
        d.status = st;
        return d;
    endfunction

    function automatic void add_key(logic [2:0] op, logic [3:0] digit);
        t_key k;
        k.op = op;
        k.digit = digit;
        k.fixed = 1'b0;
        k.value = 0;
        k.changed = 1'b0;
        k.status = ST_OK;
        keys.push_back(k);
    endfunction

    function automatic void add_checked(logic [2:0] op, logic [3:0] digit,
                                        logic [63:0] value, logic changed, logic [1:0] st);
        t_key k;
        k.op = op;
        k.digit = digit;
        k.fixed = 1'b1;
        k.value = value;
        k.changed = changed;
        k.status = st;
        keys.push_back(k);
    endfunction

    function automatic void add_number(int n);
        for (int i = 0; i < n; i++)
            add_key(OP_DIGIT, ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                                           : 4'($urandom_range(0, 9)));
    endfunction

    // Directed table, then random calculations
    initial begin
        int ops_left;
        add_checked(OP_EQUALS, 4'd0, 64'd0, 1'b1, ST_OK);        // equals, nothing pending
        add_checked(OP_EQUALS, 4'd0, 64'd0, 1'b1, ST_OK);        // repeat equals, no operator
        add_checked(OP_DIGIT, 4'd9, 64'd9 << 16, 1'b1, ST_OK);
        add_checked(OP_DIGIT, 4'd15, 64'd99 << 16, 1'b1, ST_OK); // above nine reads as nine
        add_checked(OP_CLEAR, 4'd15, 64'd0, 1'b1, ST_OK);
        // divide by zero, then repeated
        add_checked(OP_DIGIT, 4'd5, 64'd5 << 16, 1'b1, ST_OK);
        add_checked(OP_DIVIDE, 4'd0, 64'd5 << 16, 1'b0, ST_OK);
        add_checked(OP_EQUALS, 4'd0, VMAX, 1'b1, ST_DZ);
        add_checked(OP_EQUALS, 4'd0, VMAX, 1'b1, ST_DZ);
        add_checked(OP_CLEAR, 4'd0, 64'd0, 1'b1, ST_OK);
        // power key with nothing pending, saturating power
        add_key(OP_DIGIT, 4'd9);
        add_key(OP_POWER, 4'd0);
        add_key(OP_DIGIT, 4'd9);
        add_checked(OP_DIGIT, 4'd9, 64'd99 << 16, 1'b1, ST_OK);
        add_checked(OP_EQUALS, 4'd0, VMAX, 1'b1, ST_OVF);
        // negative base through an odd power, then chained operators
        add_key(OP_CLEAR, 4'd0);
        add_key(OP_MINUS, 4'd0);
        add_key(OP_DIGIT, 4'd2);
        add_key(OP_POWER, 4'd0);
        add_key(OP_DIGIT, 4'd7);
        add_key(OP_TIMES, 4'd0);
        add_key(OP_DIGIT, 4'd3);
        add_key(OP_PLUS, 4'd0);
        add_key(OP_DIGIT, 4'd8);
        add_key(OP_EQUALS, 4'd0);

        ops_left = RANDOM_KEYS;
        while (ops_left > 0) begin
            int before_n;
            before_n = keys.size();
            case ($urandom_range(0, 9))
                0: add_key(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
                1: add_key(OP_CLEAR, 4'($urandom_range(0, 15)));
                default: begin
                    logic [2:0] op;
                    if ($urandom_range(0, 3) == 0)
                        add_key(OP_MINUS, 4'd0);   // minus key ahead of the number
                    add_number($urandom_range(1, 4));
                    for (int j = $urandom_range(1, 3); j > 0; j--) begin
                        op = 3'($urandom_range(OP_PLUS, OP_POWER));
                        add_key(op, 4'($urandom_range(0, 15)));
                        if ($urandom_range(0, 7) != 0)
                            add_number((op == OP_POWER) ? $urandom_range(1, 2)
                                                        : $urandom_range(1, 5));
                    end
                    for (int j = $urandom_range(0, 2); j >= 0; j--)
                        add_key(OP_EQUALS, 4'($urandom_range(0, 15)));
                end
            endcase
            ops_left -= keys.size() - before_n;
        end
    end

    // Drive keys at the falling edge, with random gaps before the tail
    initial begin
        int total;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        total = keys.size();
        for (int n = 0; n < total; n++) begin
            if (n >= total - TAIL_KEYS)
                tail_phase = 1'b1;
            if (!tail_phase && $urandom_range(0, 3) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end
            cur_key = keys[n];
            i_op <= cur_key.op;
            i_digit <= cur_key.digit;
            i_in_valid <= 1'b1;
            // hold until accepted
            do @(posedge i_clk); while (!o_in_ready);
            @(negedge i_clk);
        end
        i_in_valid <= 1'b0;
        keys_done = 1'b1;
    end

    // Stall the result side in random bursts
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!tail_phase && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
        end
    end

    // Predict on accepted keys, compare on accepted results
    always @(posedge i_clk) begin
        t_display exp_d, got;
        if (!i_rst_n) begin
            calc_clear();
        end else begin
            if (i_in_valid && o_in_ready) begin
                exp_d = calc_press(i_op, i_digit);
                if (cur_key.fixed) begin
                    exp_d.value = cur_key.value;
                    exp_d.changed = cur_key.changed;
                    exp_d.status = cur_key.status;
                end
                pending_displays.push_back(exp_d);
            end
            if (o_out_valid && i_out_ready) begin
                got.value = o_display_value;
                got.changed = o_display_changed;
                got.status = o_status;
                if (pending_displays.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual value %0d",
                             $realtime, got.value);
                    errors++;
                end else begin
                    exp_d = pending_displays.pop_front();
                    checked++;
                    if (got.value !== exp_d.value) begin
                        $display("%0t: display_value expected %0d actual %0d",
                                 $realtime, exp_d.value, got.value);
                        errors++;
                    end
                    if (got.changed !== exp_d.changed) begin
                        $display("%0t: display_changed expected %0b actual %0b",
                                 $realtime, exp_d.changed, got.changed);
                        errors++;
                    end
                    if (got.status !== exp_d.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, exp_d.status, got.status);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Drain and report
    initial begin
        wait (keys_done);
        while (pending_displays.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (pending_displays.size() != 0)
            errors++;
        $display("Ran %0d key presses (directed and random chains), %0d results checked,",
                 keys.size(), checked);
        $display("%0d mismatches over %0d cycles.", errors, cycles);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
